// ----- rtl/rstats_pkg.sv -----
// Shared types and constants for the three-channel running statistics block.
`timescale 1ns / 1ps
package rstats_pkg;

   localparam int CHANNELS  = 3;
   localparam int CHAN_BITS = 2;

   localparam logic [CHAN_BITS-1:0] CHAN_TEMP  = 2'd0;
   localparam logic [CHAN_BITS-1:0] CHAN_HUMID = 2'd1;
   localparam logic [CHAN_BITS-1:0] CHAN_LIGHT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_LOAD
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/rstats_if.sv -----
// Valid/ready channel interfaces for sample words and statistics words.
`timescale 1ns / 1ps
interface rstats_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] temperature;
   logic signed [SAMPLE_BITS-1:0] humidity;
   logic signed [SAMPLE_BITS-1:0] light_level;

   modport source (output valid, output temperature, output humidity, output light_level,
                   input ready);
   modport sink   (input valid, input temperature, input humidity, input light_level,
                   output ready);
endinterface

interface rstats_rsp_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24
);
   logic                          valid;
   logic                          ready;
   logic        [COUNT_BITS-1:0]  sample_count;
   logic signed [SAMPLE_BITS-1:0] mean_temperature;
   logic signed [SAMPLE_BITS-1:0] mean_humidity;
   logic signed [SAMPLE_BITS-1:0] mean_light;
   logic signed [SAMPLE_BITS-1:0] lowest_temperature;
   logic signed [SAMPLE_BITS-1:0] highest_temperature;
   logic signed [SAMPLE_BITS-1:0] lowest_humidity;
   logic signed [SAMPLE_BITS-1:0] highest_humidity;
   logic signed [SAMPLE_BITS-1:0] lowest_light;
   logic signed [SAMPLE_BITS-1:0] highest_light;
   logic                          count_saturated;

   modport source (output valid, output sample_count, output mean_temperature,
                   output mean_humidity, output mean_light, output lowest_temperature,
                   output highest_temperature, output lowest_humidity,
                   output highest_humidity, output lowest_light, output highest_light,
                   output count_saturated, input ready);
   modport sink   (input valid, input sample_count, input mean_temperature,
                   input mean_humidity, input mean_light, input lowest_temperature,
                   input highest_temperature, input lowest_humidity,
                   input highest_humidity, input lowest_light, input highest_light,
                   input count_saturated, output ready);
endinterface

// ----- rtl/rstats_accum.sv -----
// Per-channel running sums, minima, maxima and the saturating sample count.
`timescale 1ns / 1ps
module rstats_accum #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      update,
   input  logic signed [SAMPLE_BITS-1:0]             sample  [rstats_pkg::CHANNELS],
   output logic signed [SAMPLE_BITS+COUNT_BITS-1:0]  sum_out [rstats_pkg::CHANNELS],
   output logic signed [SAMPLE_BITS-1:0]             min_out [rstats_pkg::CHANNELS],
   output logic signed [SAMPLE_BITS-1:0]             max_out [rstats_pkg::CHANNELS],
   output logic        [COUNT_BITS-1:0]              count_out,
   output logic                                      full_out
);
   import rstats_pkg::*;

   localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAXV = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MINV = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic        [COUNT_BITS-1:0]  COUNT_FULL  = {COUNT_BITS{1'b1}};

   logic signed [SUM_BITS-1:0]    sum_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] min_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] max_ff [CHANNELS];
   logic        [COUNT_BITS-1:0]  count_ff;
   logic                          full_ff;
   logic                          full_now;

   assign full_now = (count_ff == COUNT_FULL);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c] <= '0;
            min_ff[c] <= SAMPLE_MAXV;
            max_ff[c] <= SAMPLE_MINV;
         end
         count_ff <= '0;
         full_ff  <= 1'b0;
      end else if (update) begin
         for (int c = 0; c < CHANNELS; c++) begin
            // hold the sums once the count is full
            if (!full_now) begin
               sum_ff[c] <= sum_ff[c] + {{COUNT_BITS{sample[c][SAMPLE_BITS-1]}}, sample[c]};
            end
            if (sample[c] < min_ff[c]) begin
               min_ff[c] <= sample[c];
            end
            if (sample[c] > max_ff[c]) begin
               max_ff[c] <= sample[c];
            end
         end
         if (!full_now) begin
            count_ff <= count_ff + COUNT_BITS'(1);
         end
         full_ff <= full_now;
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         sum_out[c] = sum_ff[c];
         min_out[c] = min_ff[c];
         max_out[c] = max_ff[c];
      end
   end

   assign count_out = count_ff;
   assign full_out  = full_ff;

   a_count_monotonic : assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> count_ff >= $past(count_ff))
      else $error("sample count went backward");

   a_full_means_count_full : assert property (@(posedge clock) disable iff (reset)
      full_ff |-> count_ff == COUNT_FULL)
      else $error("saturated flag without full count");

   a_full_holds_sum : assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(update) && $past(full_now) |-> sum_ff[0] == $past(sum_ff[0]))
      else $error("sum moved while count full");

endmodule

// ----- rtl/rstats_divider.sv -----
// Shared restoring divider: signed sum over unsigned count, one quotient bit a cycle.
`timescale 1ns / 1ps
module rstats_divider #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic signed [SAMPLE_BITS+COUNT_BITS-1:0] numer,
   input  logic        [COUNT_BITS-1:0]             denom,
   output logic signed [SAMPLE_BITS-1:0]            quot,
   output rstats_pkg::div_status_type               status
);
   import rstats_pkg::*;

   localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
   localparam int STEP_BITS = $clog2(SAMPLE_BITS);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] shift_ff, shift_in;
   logic [COUNT_BITS-1:0]  den_ff, den_in;
   logic                   neg_ff, neg_in;
   logic                   zero_ff, zero_in;

   logic [SUM_BITS-1:0]    mag;
   logic [COUNT_BITS:0]    trial;
   logic [COUNT_BITS:0]    diff;
   logic                   fits;

   assign mag   = numer[SUM_BITS-1] ? (~numer + SUM_BITS'(1)) : numer;
   assign trial = {rem_ff, shift_ff[SAMPLE_BITS-1]};
   assign fits  = (trial >= {1'b0, den_ff});
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      if (start && !busy_ff) begin
         // the quotient fits in SAMPLE_BITS, so the upper bits start as the remainder
         busy_in  = 1'b1;
         step_in  = STEP_BITS'(SAMPLE_BITS - 1);
         rem_in   = mag[SUM_BITS-1:SAMPLE_BITS];
         shift_in = mag[SAMPLE_BITS-1:0];
         den_in   = denom;
         neg_in   = numer[SUM_BITS-1];
         zero_in  = (denom == '0);
      end else if (busy_ff) begin
         rem_in   = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
         shift_in = {shift_ff[SAMPLE_BITS-2:0], fits};
         step_in  = step_ff - STEP_BITS'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
   end

   always_comb begin
      priority if (zero_ff) begin
         quot = '0;
      end else if (neg_ff) begin
         quot = -shift_ff;
      end else begin
         quot = shift_ff;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a run");

   a_rem_below_den : assert property (@(posedge clock) disable iff (reset)
      busy_ff && !zero_ff |-> rem_ff < den_ff)
      else $error("partial remainder not below divisor");

   a_done_at_last_step : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(step_ff) == '0)
      else $error("divider finished early");

endmodule

// ----- rtl/three_channel_running_stats.sv -----
// Top level of the three-channel running min/max/mean block with its sequencer.
//
//   channel   dir   payload                                          handshake
//   req_chan  in    temperature, humidity, light_level               valid/ready
//   rsp_chan  out   sample_count, 3 means, 3 minima, 3 maxima, flag  valid/ready
//
// A word is accepted only while idle; the next ready waits until the one shared
// divider, turning out one quotient bit a cycle, has produced each of the three
// means in turn and the word has been loaded into the output register.
// Reset is synchronous; it clears the sums and count and sets minima and maxima
// to their extremes. The result sits in an output register, so a stalled rsp_chan
// holds the last word while the next sample is accepted and divided.
`timescale 1ns / 1ps
module three_channel_running_stats #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 24
) (
   input logic         clock,
   input logic         reset,
   rstats_req_if.sink  req_chan,
   rstats_rsp_if.source rsp_chan
);
   import rstats_pkg::*;

   localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;

   seq_state_type           state_ff, state_in;
   logic [CHAN_BITS-1:0]    chan_ff, chan_in;
   logic signed [SAMPLE_BITS-1:0] mean_ff [CHANNELS];
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    accept;
   logic                    div_start;
   logic                    capture;
   logic                    load;

   logic signed [SAMPLE_BITS-1:0] sample  [CHANNELS];
   logic signed [SUM_BITS-1:0]    sum_w   [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] min_w   [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] max_w   [CHANNELS];
   logic        [COUNT_BITS-1:0]  count_w;
   logic                          full_w;
   logic signed [SAMPLE_BITS-1:0] quot_w;
   div_status_type                div_status;

   logic        [COUNT_BITS-1:0]  out_count_ff;
   logic signed [SAMPLE_BITS-1:0] out_mean_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] out_min_ff  [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] out_max_ff  [CHANNELS];
   logic                          out_full_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign sample[CHAN_TEMP]  = req_chan.temperature;
   assign sample[CHAN_HUMID] = req_chan.humidity;
   assign sample[CHAN_LIGHT] = req_chan.light_level;

   rstats_accum #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .update    (accept),
      .sample    (sample),
      .sum_out   (sum_w),
      .min_out   (min_w),
      .max_out   (max_w),
      .count_out (count_w),
      .full_out  (full_w)
   );

   rstats_divider #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (sum_w[chan_ff]),
      .denom  (count_w),
      .quot   (quot_w),
      .status (div_status)
   );

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      div_start    = 1'b0;
      capture      = 1'b0;
      load         = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               chan_in  = CHAN_TEMP;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (!div_status.busy) begin
               div_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_status.done) begin
               capture = 1'b1;
               if (chan_ff == CHAN_LIGHT) begin
                  state_in = ST_LOAD;
               end else begin
                  chan_in  = chan_ff + CHAN_BITS'(1);
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_LOAD: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= CHAN_TEMP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         mean_ff[chan_ff] <= quot_w;
      end
      if (load) begin
         out_count_ff <= count_w;
         out_full_ff  <= full_w;
         for (int c = 0; c < CHANNELS; c++) begin
            out_mean_ff[c] <= mean_ff[c];
            out_min_ff[c]  <= min_w[c];
            out_max_ff[c]  <= max_w[c];
         end
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.sample_count        = out_count_ff;
   assign rsp_chan.mean_temperature    = out_mean_ff[CHAN_TEMP];
   assign rsp_chan.mean_humidity       = out_mean_ff[CHAN_HUMID];
   assign rsp_chan.mean_light          = out_mean_ff[CHAN_LIGHT];
   assign rsp_chan.lowest_temperature  = out_min_ff[CHAN_TEMP];
   assign rsp_chan.highest_temperature = out_max_ff[CHAN_TEMP];
   assign rsp_chan.lowest_humidity     = out_min_ff[CHAN_HUMID];
   assign rsp_chan.highest_humidity    = out_max_ff[CHAN_HUMID];
   assign rsp_chan.lowest_light        = out_min_ff[CHAN_LIGHT];
   assign rsp_chan.highest_light       = out_max_ff[CHAN_LIGHT];
   assign rsp_chan.count_saturated     = out_full_ff;

   a_start_when_free : assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy && !div_status.done)
      else $error("divider started while in use");

   a_load_after_last : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> chan_ff == CHAN_LIGHT)
      else $error("result loaded before all means");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      load |-> !rsp_valid_ff || rsp_chan.ready)
      else $error("output word overwritten while stalled");

   a_count_nonzero_at_load : assert property (@(posedge clock) disable iff (reset)
      load |-> count_w != '0)
      else $error("result with zero count");

endmodule

// ----- tb/three_channel_running_stats_test.sv -----
// Self-checking bench: random sample triples in, running count/mean/min/max out.
`timescale 1ns / 1ps
module three_channel_running_stats_test;
   import rstats_pkg::*;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 24;
   localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
   localparam int RANDOM_ITEMS = 1030;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 200;
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = {COUNT_BITS{1'b1}};

   localparam int SHAPE_ANY      = 0;
   localparam int SHAPE_NEAR_MAX = 1;
   localparam int SHAPE_NEAR_MIN = 2;
   localparam int SHAPE_AROUND_0 = 3;
   localparam int SHAPE_CORNERS  = 4;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] temperature;
      logic signed [SAMPLE_BITS-1:0] humidity;
      logic signed [SAMPLE_BITS-1:0] light_level;
   } sample_triple_type;

   typedef struct {
      logic        [COUNT_BITS-1:0]  sample_count;
      logic signed [SAMPLE_BITS-1:0] mean_temperature;
      logic signed [SAMPLE_BITS-1:0] mean_humidity;
      logic signed [SAMPLE_BITS-1:0] mean_light;
      logic signed [SAMPLE_BITS-1:0] lowest_temperature;
      logic signed [SAMPLE_BITS-1:0] highest_temperature;
      logic signed [SAMPLE_BITS-1:0] lowest_humidity;
      logic signed [SAMPLE_BITS-1:0] highest_humidity;
      logic signed [SAMPLE_BITS-1:0] lowest_light;
      logic signed [SAMPLE_BITS-1:0] highest_light;
      logic                          count_saturated;
   } stats_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rstats_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   rstats_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) rsp_chan ();

   three_channel_running_stats #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sample_triple_type sample_backlog [$];
   stats_word_type    running_stats_due [$];
   sample_triple_type sample_on_bus;
   int           errors = 0;
   int           send_gap = 0;
   int           take_stall = 0;
   bit           send_steady = 1'b0;
   bit           take_steady = 1'b0;
   int           quiet_cycles = 0;

   // running state of the block as seen from outside
   logic signed [SUM_BITS-1:0]    sum_acc  [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] low_acc  [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] high_acc [CHANNELS];
   logic        [COUNT_BITS-1:0]  count_acc;

   function automatic stats_word_type accumulate_sample(sample_triple_type s);
      logic signed [SAMPLE_BITS-1:0] v [CHANNELS];
      logic signed [SAMPLE_BITS-1:0] mean [CHANNELS];
      longint                        quotient;
      stats_word_type                w;
      bit                            full;
      int                            c;
      v[CHAN_TEMP]  = s.temperature;
      v[CHAN_HUMID] = s.humidity;
      v[CHAN_LIGHT] = s.light_level;
      full = (count_acc == COUNT_FULL);
      for (c = 0; c < CHANNELS; c++) begin
         if (!full) sum_acc[c] = sum_acc[c] + SUM_BITS'(v[c]);
         if (v[c] < low_acc[c]) low_acc[c] = v[c];
         if (v[c] > high_acc[c]) high_acc[c] = v[c];
      end
      if (!full) count_acc = count_acc + 1'b1;
      for (c = 0; c < CHANNELS; c++) begin
         // SystemVerilog division truncates toward zero
         quotient = (count_acc == 0) ? 0 : longint'(sum_acc[c]) / longint'(count_acc);
         mean[c] = SAMPLE_BITS'(quotient);
      end
      w.sample_count        = count_acc;
      w.mean_temperature    = mean[CHAN_TEMP];
      w.mean_humidity       = mean[CHAN_HUMID];
      w.mean_light          = mean[CHAN_LIGHT];
      w.lowest_temperature  = low_acc[CHAN_TEMP];
      w.highest_temperature = high_acc[CHAN_TEMP];
      w.lowest_humidity     = low_acc[CHAN_HUMID];
      w.highest_humidity    = high_acc[CHAN_HUMID];
      w.lowest_light        = low_acc[CHAN_LIGHT];
      w.highest_light       = high_acc[CHAN_LIGHT];
      w.count_saturated     = full;
      return w;
   endfunction

   function automatic int pick_gap(bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(8, 1);
      return $urandom_range(120, 9);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] draw_value(int shape);
      case (shape)
         SHAPE_NEAR_MAX: return 16'h7FFF - 16'($urandom_range(255));
         SHAPE_NEAR_MIN: return 16'h8000 + 16'($urandom_range(255));
         SHAPE_AROUND_0: return 16'($urandom_range(200)) - 16'd100;
         SHAPE_CORNERS: begin
            case ($urandom_range(3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic void queue_sample(logic [SAMPLE_BITS-1:0] t, logic [SAMPLE_BITS-1:0] h,
                                        logic [SAMPLE_BITS-1:0] l);
      sample_triple_type s;
      s.temperature = t;
      s.humidity    = h;
      s.light_level = l;
      sample_backlog.push_back(s);
   endfunction

   task automatic check_field(string label, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", label, want, got);
         errors++;
      end
   endtask

   // sample driver
   always @(posedge clock) begin
      logic next_valid;
      int   c;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= 0;
         for (c = 0; c < CHANNELS; c++) begin
            sum_acc[c]  = '0;
            low_acc[c]  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            high_acc[c] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         end
         count_acc = '0;
      end else begin
         next_valid = req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            running_stats_due.push_back(accumulate_sample(sample_on_bus));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (sample_backlog.size() > 0) begin
               sample_on_bus = sample_backlog.pop_front();
               req_chan.temperature <= sample_on_bus.temperature;
               req_chan.humidity    <= sample_on_bus.humidity;
               req_chan.light_level <= sample_on_bus.light_level;
               next_valid = 1'b1;
               if ($urandom_range(49) == 0) send_steady = !send_steady;
               send_gap <= pick_gap(send_steady);
            end
         end
         req_chan.valid <= next_valid;
      end
   end

   // result monitor and backpressure
   always @(posedge clock) begin
      stats_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_stall <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (running_stats_due.size() == 0) begin
               $error("result word with none expected: count %0d", rsp_chan.sample_count);
               errors++;
            end else begin
               want = running_stats_due.pop_front();
               check_field("sample_count", want.sample_count, rsp_chan.sample_count);
               check_field("mean_temperature", want.mean_temperature,
                           rsp_chan.mean_temperature);
               check_field("mean_humidity", want.mean_humidity, rsp_chan.mean_humidity);
               check_field("mean_light", want.mean_light, rsp_chan.mean_light);
               check_field("lowest_temperature", want.lowest_temperature,
                           rsp_chan.lowest_temperature);
               check_field("highest_temperature", want.highest_temperature,
                           rsp_chan.highest_temperature);
               check_field("lowest_humidity", want.lowest_humidity,
                           rsp_chan.lowest_humidity);
               check_field("highest_humidity", want.highest_humidity,
                           rsp_chan.highest_humidity);
               check_field("lowest_light", want.lowest_light, rsp_chan.lowest_light);
               check_field("highest_light", want.highest_light, rsp_chan.highest_light);
               check_field("count_saturated", want.count_saturated,
                           rsp_chan.count_saturated);
            end
         end
         if (take_stall > 0) begin
            take_stall <= take_stall - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(49) == 0) take_steady = !take_steady;
            if ($urandom_range(3) == 0) take_stall <= pick_gap(take_steady);
         end
      end
   end

   // end the run if nothing moves while work is outstanding
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (sample_backlog.size() > 0 || req_chan.valid
                   || running_stats_due.size() > 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int n;
      int c;
      int shape;
      logic [SAMPLE_BITS-1:0] v [CHANNELS];

      // extremes first: a minimum sample leaves the maxima at their reset value
      queue_sample(16'h8000, 16'h8000, 16'h8000);
      queue_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
      queue_sample(16'h0000, 16'h0000, 16'h0000);
      queue_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_sample(16'h0001, 16'hFFFF, 16'h0000);
      queue_sample(16'h5555, 16'hAAAA, 16'h5555);
      queue_sample(16'hAAAA, 16'h5555, 16'hAAAA);
      queue_sample(16'h7FFF, 16'h8000, 16'h0000);
      queue_sample(16'h8000, 16'h7FFF, 16'hFFFF);
      // negative sums with remainders check truncation toward zero
      queue_sample(16'hFFF9, 16'h0007, 16'hFFFD);
      queue_sample(16'h8000, 16'h8001, 16'h8000);
      queue_sample(16'h8000, 16'h8000, 16'h8002);
      queue_sample(16'h0003, 16'hFFFB, 16'h0002);
      queue_sample(16'h8001, 16'h7FFE, 16'h0001);
      queue_sample(16'h7FFF, 16'h7FFF, 16'h8000);
      queue_sample(16'h00FF, 16'hFF00, 16'h0F0F);

      // the saturated count lies far beyond this run's length
      shape = SHAPE_ANY;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) shape = $urandom_range(SHAPE_CORNERS);
         for (c = 0; c < CHANNELS; c++)
            v[c] = ($urandom_range(4) == 0) ? draw_value(SHAPE_ANY) : draw_value(shape);
         queue_sample(v[CHAN_TEMP], v[CHAN_HUMID], v[CHAN_LIGHT]);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // check at the falling edge so that queue and valid have settled
      @(negedge clock);
      while (sample_backlog.size() > 0 || req_chan.valid || running_stats_due.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
